// File: rtl/core/bbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbe_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int W_CNT_W      = ADDR_W + 1;
   localparam int H_W          = 11;
   localparam int CSR_W        = 11;
   localparam int CSR_IDX_W    = 2;
   localparam int NCELL        = 3;
   localparam int PART_W       = 10;
   localparam int SUM_W        = 12;
   localparam int CNT_W        = 4;
   localparam int RECIP_W      = 17;
   localparam int RECIP_SHIFT  = 16;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // window column: [0] top row, [1] middle row, [2] bottom row
   typedef pixel_type [2:0] column_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_entry_type;

   typedef struct packed {
      logic [PART_W-1:0] red;
      logic [PART_W-1:0] green;
      logic [PART_W-1:0] blue;
   } part_sum_type;

   typedef part_sum_type [NCELL-1:0] part_vec_type;

   typedef struct packed {
      logic       drain;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_of_run;
      logic       frame_done;
   } rsp_word_type;

   // number of pixels averaged: rows in use times columns in use
   function automatic logic [CNT_W-1:0] count_of(input logic [2:0] rm, input logic [2:0] cm);
      logic [CNT_W-1:0] nr;
      logic [CNT_W-1:0] nc;
      nr = CNT_W'(rm[0]) + CNT_W'(rm[1]) + CNT_W'(rm[2]);
      nc = CNT_W'(cm[0]) + CNT_W'(cm[1]) + CNT_W'(cm[2]);
      return CNT_W'(nr * nc);
   endfunction

   // ceil(2^16 / count); exact floor for every dividend below 2^15
   function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] k;
      case (cnt)
         4'd1:    k = 17'd65536;
         4'd2:    k = 17'd32768;
         4'd3:    k = 17'd21846;
         4'd4:    k = 17'd16384;
         4'd6:    k = 17'd10923;
         4'd9:    k = 17'd7282;
         default: k = 17'd65536;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/bbe_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bbe_cell (
   input  wire logic                clock,
   input  wire logic                shift_en,
   input  wire bbe_pkg::column_type col_in,
   output bbe_pkg::column_type      col_out,
   input  wire logic [2:0]          row_mask,
   input  wire logic                col_en,
   output bbe_pkg::part_sum_type    part_sum
);
   import bbe_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   // masked column sum per channel
   always_comb begin
      part_sum = '0;
      for (int i = 0; i < 3; i++) begin
         if (row_mask[i] && col_en) begin
            part_sum.red   = part_sum.red   + PART_W'(col_ff[i].red);
            part_sum.green = part_sum.green + PART_W'(col_ff[i].green);
            part_sum.blue  = part_sum.blue  + PART_W'(col_ff[i].blue);
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bbe_mean.sv
`timescale 1ns / 1ps
`default_nettype none
module bbe_mean (
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire bbe_pkg::part_vec_type      parts,
   input  wire logic [bbe_pkg::CNT_W-1:0]  count,
   output bbe_pkg::pixel_type              mean
);
   import bbe_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W;

   logic [SUM_W-1:0]   m_red_ff, m_green_ff, m_blue_ff;
   logic [SUM_W-1:0]   m_red_in, m_green_in, m_blue_in;
   logic [RECIP_W-1:0] k_ff;
   logic [PROD_W-1:0]  prod_red, prod_green, prod_blue;
   logic [SUM_W-1:0]   half;

   // round half up: (2s+n)/(2n) == (s + n/2) / n
   always_comb begin
      half       = SUM_W'(count >> 1);
      m_red_in   = half;
      m_green_in = half;
      m_blue_in  = half;
      for (int k = 0; k < NCELL; k++) begin
         m_red_in   = m_red_in   + SUM_W'(parts[k].red);
         m_green_in = m_green_in + SUM_W'(parts[k].green);
         m_blue_in  = m_blue_in  + SUM_W'(parts[k].blue);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         m_red_ff   <= m_red_in;
         m_green_ff <= m_green_in;
         m_blue_ff  <= m_blue_in;
         k_ff       <= recip_of(count);
      end
   end

   assign prod_red   = PROD_W'(m_red_ff)   * PROD_W'(k_ff);
   assign prod_green = PROD_W'(m_green_ff) * PROD_W'(k_ff);
   assign prod_blue  = PROD_W'(m_blue_ff)  * PROD_W'(k_ff);

   assign mean.red   = prod_red[RECIP_SHIFT+7:RECIP_SHIFT];
   assign mean.green = prod_green[RECIP_SHIFT+7:RECIP_SHIFT];
   assign mean.blue  = prod_blue[RECIP_SHIFT+7:RECIP_SHIFT];

endmodule
`default_nettype wire

// File: rtl/core/bbe_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module bbe_line_buf (
   input  wire logic                        clock,
   input  wire logic [bbe_pkg::ADDR_W-1:0]  rd_addr,
   output bbe_pkg::line_entry_type          rd_data,
   input  wire logic                        wr_en,
   input  wire logic [bbe_pkg::ADDR_W-1:0]  wr_addr,
   input  wire bbe_pkg::line_entry_type     wr_data
);
   import bbe_pkg::*;

   // two earlier rows side by side, one word per column
   line_entry_type mem_ff [MAX_WIDTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/box_blur_3x3_edge_average.sv
`timescale 1ns / 1ps
`default_nettype none
// 3x3 box blur, mean of in-frame neighbors, raster RGB words in and out.
// Each pixel word gives no, one or two results and each drain word one; ignored words go
// straight back to idle. The sequence follows the registered line store read and the one
// shared averaging unit (sum stage, then reciprocal multiply into the output reg).
// Reset is synchronous: control and counters clear, width and height go to 1; window and
// line store are not cleared (their entries are only used after being written).
module box_blur_3x3_edge_average (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire bbe_pkg::req_word_type         req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output bbe_pkg::rsp_word_type              rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [bbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bbe_pkg::CSR_W-1:0]     csr_wdata
);
   import bbe_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PX_WR = 3'd1;  // line data back: write store, shift window
   localparam logic [2:0] ST_DR_A  = 3'd2;  // drain: column c-1 arrives
   localparam logic [2:0] ST_DR_B  = 3'd3;  // drain: column c arrives
   localparam logic [2:0] ST_DR_C  = 3'd4;  // drain: column c+1 arrives
   localparam logic [2:0] ST_SUM   = 3'd5;  // masked window sum into the averager
   localparam logic [2:0] ST_OUT   = 3'd6;  // multiply result into output register

   function automatic logic [W_CNT_W-1:0] eff_width(input logic [CSR_W-1:0] v);
      logic [W_CNT_W-1:0] w;
      if (v == '0) begin
         w = W_CNT_W'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         w = W_CNT_W'(MAX_WIDTH);
      end else begin
         w = W_CNT_W'(v);
      end
      return w;
   endfunction

   function automatic logic [H_W-1:0] eff_height(input logic [CSR_W-1:0] v);
      logic [H_W-1:0] h;
      if (v == '0) begin
         h = H_W'(1);
      end else if (32'(v) > HEIGHT_LIMIT) begin
         h = H_W'(HEIGHT_LIMIT);
      end else begin
         h = H_W'(v);
      end
      return h;
   endfunction

   // control state
   logic [2:0]         state_ff, state_in;
   logic [W_CNT_W-1:0] width_ff;
   logic [H_W-1:0]     height_ff;
   logic [H_W-1:0]     row_ff;
   logic [ADDR_W-1:0]  col_cnt_ff;
   logic [ADDR_W-1:0]  drain_cnt_ff;
   logic               sel_ff, sel_in;
   logic               rsp_valid_ff;

   // per-word plan, captured at accept
   logic               is_drain_ff;
   pixel_type          pix_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic [ADDR_W-1:0]  drain_col_ff;
   logic [2:0]         rmask_ff;     // [0] top, [1] middle, [2] bottom
   logic               e1_ff, e2_ff; // first / row-end result pending
   logic [2:0]         cm1_ff, cm2_ff; // [0] left, [1] center, [2] right
   logic               fdone_ff;
   rsp_word_type       rsp_data_ff;

   logic               accept;
   logic               reg_hit;
   logic [ADDR_W-1:0]  col_cur;
   logic [W_CNT_W-1:0] col_next;
   logic [W_CNT_W-1:0] dr_next;
   logic               px_ok, dr_ok, last_col;
   logic [ADDR_W-1:0]  rd_addr;
   line_entry_type     rd_data;
   line_entry_type     wr_data;
   logic               wr_en;
   logic               shift_en;
   column_type         new_col;
   column_type         cell_in  [NCELL];
   column_type         cell_out [NCELL];
   part_vec_type       parts;
   logic [2:0]         cmask;
   logic [CNT_W-1:0]   count;
   pixel_type          mean;
   logic               out_free;
   logic               out_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign reg_hit   = (csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT);

   assign col_cur  = (W_CNT_W'(col_cnt_ff) >= width_ff) ? '0 : col_cnt_ff;
   assign col_next = W_CNT_W'(col_cur) + W_CNT_W'(1);
   assign dr_next  = W_CNT_W'(drain_cnt_ff) + W_CNT_W'(1);
   assign px_ok    = (row_ff < height_ff);
   assign dr_ok    = (row_ff == height_ff) && (W_CNT_W'(drain_cnt_ff) < width_ff);
   assign last_col = (W_CNT_W'(col_cur) == (width_ff - W_CNT_W'(1)));

   // frame position and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= W_CNT_W'(1);
         height_ff    <= H_W'(1);
         row_ff       <= '0;
         col_cnt_ff   <= '0;
         drain_cnt_ff <= '0;
      end else if (csr_we) begin
         if (reg_hit) begin
            case (csr_index)
               REG_FRAME_WIDTH:  width_ff  <= eff_width(csr_wdata);
               REG_FRAME_HEIGHT: height_ff <= eff_height(csr_wdata);
               default: ;
            endcase
            row_ff       <= '0;
            col_cnt_ff   <= '0;
            drain_cnt_ff <= '0;
         end
      end else if (accept) begin
         if (req_data.drain) begin
            if (dr_ok) begin
               if (dr_next == width_ff) begin
                  row_ff       <= '0;
                  col_cnt_ff   <= '0;
                  drain_cnt_ff <= '0;
               end else begin
                  drain_cnt_ff <= ADDR_W'(dr_next);
               end
            end
         end else if (px_ok) begin
            if (col_next >= width_ff) begin
               col_cnt_ff <= '0;
               row_ff     <= row_ff + H_W'(1);
            end else begin
               col_cnt_ff <= ADDR_W'(col_next);
            end
         end
      end
   end

   // plan for the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         is_drain_ff  <= req_data.drain;
         pix_ff       <= '{red: req_data.red_in, green: req_data.green_in,
                           blue: req_data.blue_in};
         wr_addr_ff   <= col_cur;
         drain_col_ff <= drain_cnt_ff;
         if (req_data.drain) begin
            rmask_ff <= {1'b0, 1'b1, height_ff >= H_W'(2)};
            e1_ff    <= 1'b1;
            e2_ff    <= 1'b0;
            cm1_ff   <= {dr_next < width_ff, 1'b1, drain_cnt_ff != '0};
            fdone_ff <= (dr_next == width_ff);
         end else begin
            rmask_ff <= {1'b1, 1'b1, row_ff >= H_W'(2)};
            e1_ff    <= (row_ff != '0) && (col_cur != '0);
            e2_ff    <= (row_ff != '0) && last_col;
            cm1_ff   <= {1'b1, 1'b1, col_cur >= ADDR_W'(2)};
            fdone_ff <= 1'b0;
         end
         cm2_ff <= {1'b1, col_cur != '0, 1'b0};
      end
   end

   // sequencer
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == ST_OUT) && out_free;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.drain) begin
                  state_in = dr_ok ? ST_DR_A : ST_IDLE;
               end else begin
                  state_in = px_ok ? ST_PX_WR : ST_IDLE;
               end
            end
         end
         ST_PX_WR: begin
            if (e1_ff) begin
               state_in = ST_SUM;
               sel_in   = 1'b0;
            end else if (e2_ff) begin
               state_in = ST_SUM;
               sel_in   = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DR_A: state_in = ST_DR_B;
         ST_DR_B: state_in = ST_DR_C;
         ST_DR_C: begin
            state_in = ST_SUM;
            sel_in   = 1'b0;
         end
         ST_SUM:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               if (!sel_ff && e2_ff) begin
                  state_in = ST_SUM;
                  sel_in   = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // line store: pixel reads its column; drain reads c-1, c, c+1 in turn
   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = req_data.drain ? (drain_cnt_ff - ADDR_W'(1)) : col_cur;
         ST_DR_A: rd_addr = drain_col_ff;
         ST_DR_B: rd_addr = drain_col_ff + ADDR_W'(1);
         default: rd_addr = col_cur;
      endcase
   end

   assign wr_en          = (state_ff == ST_PX_WR);
   assign wr_data.upper  = rd_data.middle;
   assign wr_data.middle = pix_ff;

   bbe_line_buf u_line_buf (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data)
   );

   // window: three column cells, new column enters on the right
   assign shift_en   = state_ff inside {ST_PX_WR, ST_DR_A, ST_DR_B, ST_DR_C};
   assign new_col[0] = rd_data.upper;
   assign new_col[1] = rd_data.middle;
   assign new_col[2] = is_drain_ff ? '0 : pix_ff;
   assign cmask      = sel_ff ? cm2_ff : cm1_ff;
   assign count      = count_of(rmask_ff, cmask);

   assign cell_in[NCELL-1] = new_col;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      if (k < NCELL - 1) begin : g_link
         assign cell_in[k] = cell_out[k+1];
      end
      bbe_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .col_in   (cell_in[k]),
         .col_out  (cell_out[k]),
         .row_mask (rmask_ff),
         .col_en   (cmask[k]),
         .part_sum (parts[k])
      );
   end

   bbe_mean u_mean (
      .clock (clock),
      .load  (state_ff == ST_SUM),
      .parts (parts),
      .count (count),
      .mean  (mean)
   );

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.red_out     <= mean.red;
         rsp_data_ff.green_out   <= mean.green;
         rsp_data_ff.blue_out    <= mean.blue;
         rsp_data_ff.last_of_run <= sel_ff || !e2_ff;
         rsp_data_ff.frame_done  <= fdone_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
